// File: rtl/bitmap_block_allocator_macros.svh
// ---------------------------------------------------------------------------
// bitmap_block_allocator_macros
// assertion macros of the allocator rtl, used by the top level only
// ---------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// clocked property, disabled while reset is asserted
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define BBA_NEVER(lbl, clk, rst_n, cond, msg) \
    `BBA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// types, codes and helper functions of the bitmap block allocator
// ---------------------------------------------------------------------------
package bba_pkg;

    localparam int ADDR_W    = 48;
    localparam int IDX_OUT_W = 11;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    // widest block index and word count over the parameter range
    localparam int IDX_MAX_W = 17;
    localparam int NW_MAX_W  = 13;
    localparam int WIU_W     = 7;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 64;

    localparam logic [WIU_W-1:0] WORDS_RESET = 7'd64;

    // opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // command kinds from front to back
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_REL   = 2'd1;
    localparam logic [1:0] CMD_RANGE = 2'd2;

    // result status
    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // register select: paddr bit 3 picks the 64-bit register slot
    localparam logic REG_WORDS = 1'b0;
    localparam logic REG_BASE  = 1'b1;

    typedef struct packed {
        logic [1:0]           kind;
        logic [IDX_MAX_W-1:0] idx;
        logic [NW_MAX_W-1:0]  nwords;
    } t_cmd;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] block_index;
        logic [ADDR_W-1:0]    granted_address;
    } t_res;

    // keeps only the lowest set bit
    function automatic logic [WORD_W-1:0] lowest_one(input logic [WORD_W-1:0] v);
        lowest_one = v & (~v + WORD_W'(1));
    endfunction

    function automatic logic [BIT_W-1:0] onehot_pos(input logic [WORD_W-1:0] oh);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (oh[i]) begin
                pos = pos | BIT_W'(i);
            end
        end
        onehot_pos = pos;
    endfunction

endpackage

// File: rtl/bba_fifo.sv
// ---------------------------------------------------------------------------
// bba_fifo
// small register queue between allocator stages
// ---------------------------------------------------------------------------
module bba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/bba_front.sv
// ---------------------------------------------------------------------------
// bba_front
// request classifier: range check and block index of release requests
// ---------------------------------------------------------------------------
module bba_front #(
    parameter int MAX_MAP_WORDS = 64,
    parameter int BLOCK_SHIFT   = 12
) (
    input  logic                        i_valid,
    input  logic                        i_opcode,
    input  logic [bba_pkg::ADDR_W-1:0]  i_block_address,
    input  logic [bba_pkg::WIU_W-1:0]   i_words_in_use,
    input  logic [bba_pkg::ADDR_W-1:0]  i_base_address,
    output logic                        o_cmd_valid,
    output bba_pkg::t_cmd               o_cmd
);

    localparam logic [bba_pkg::NW_MAX_W-1:0] MAX_NW = bba_pkg::NW_MAX_W'(MAX_MAP_WORDS);

    logic [bba_pkg::NW_MAX_W-1:0] wiu_ext;
    logic [bba_pkg::NW_MAX_W-1:0] nwords;
    logic [bba_pkg::ADDR_W-1:0]   offset;
    logic [bba_pkg::ADDR_W-1:0]   idx_full;
    logic [bba_pkg::ADDR_W-1:0]   limit;
    logic                         below;
    logic                         out_of_range;

    always_comb begin
        wiu_ext      = bba_pkg::NW_MAX_W'(i_words_in_use);
        nwords       = (wiu_ext > MAX_NW) ? MAX_NW : wiu_ext;
        below        = i_block_address < i_base_address;
        offset       = i_block_address - i_base_address;
        idx_full     = offset >> BLOCK_SHIFT;
        // region size in blocks
        limit        = bba_pkg::ADDR_W'(nwords) << bba_pkg::BIT_W;
        out_of_range = below || (idx_full >= limit);

        o_cmd_valid  = i_valid;
        o_cmd.nwords = nwords;
        o_cmd.idx    = idx_full[bba_pkg::IDX_MAX_W-1:0];
        if (i_opcode == bba_pkg::OP_ALLOC) begin
            o_cmd.kind = bba_pkg::CMD_ALLOC;
        end else if (out_of_range) begin
            o_cmd.kind = bba_pkg::CMD_RANGE;
        end else begin
            o_cmd.kind = bba_pkg::CMD_REL;
        end
    end

endmodule

// File: rtl/bba_back.sv
// ---------------------------------------------------------------------------
// bba_back
// free-map engine: word scan for allocate, read-modify-write for release
// ---------------------------------------------------------------------------
module bba_back #(
    parameter int MAX_MAP_WORDS = 64,
    parameter int BLOCK_SHIFT   = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  bba_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    input  logic [bba_pkg::ADDR_W-1:0] i_base_address,
    input  logic                       i_res_full,
    output logic                       o_res_push,
    output bba_pkg::t_res              o_res,
    output logic                       o_clearing
);

    localparam int AW   = (MAX_MAP_WORDS > 1) ? $clog2(MAX_MAP_WORDS) : 1;
    localparam int IDXW = AW + bba_pkg::BIT_W;
    localparam int NWW  = $clog2(MAX_MAP_WORDS + 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_REL  = 2'd3;

    logic [bba_pkg::WORD_W-1:0] r_mem [MAX_MAP_WORDS];
    logic [bba_pkg::WORD_W-1:0] r_rdata;

    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [IDXW-1:0] r_idx, n_idx;
    logic [NWW-1:0]  r_nw, n_nw;

    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [bba_pkg::WORD_W-1:0] wr_data;

    logic [IDXW-1:0]            cmd_idx;
    logic [bba_pkg::WORD_W-1:0] iso;
    logic [IDXW-1:0]            grant_idx;
    logic [IDXW+10:0]           grant_wide;
    logic [IDXW+10:0]           rel_wide;
    logic                       last_word;

    always_comb begin
        cmd_idx    = i_cmd.idx[IDXW-1:0];
        iso        = bba_pkg::lowest_one(r_rdata);
        grant_idx  = {r_ptr, bba_pkg::onehot_pos(iso)};
        grant_wide = (IDXW + 11)'(grant_idx);
        rel_wide   = (IDXW + 11)'(r_idx);
        last_word  = (NWW'(r_ptr) + NWW'(1)) == r_nw;
    end

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_nw       = r_nw;
        rd_en      = 1'b0;
        rd_addr    = r_ptr;
        wr_en      = 1'b0;
        wr_addr    = r_ptr;
        wr_data    = '1;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;

        unique case (r_state)
            S_CLR: begin
                wr_en = 1'b1;
                if (r_ptr == AW'(MAX_MAP_WORDS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        bba_pkg::CMD_ALLOC: begin
                            if (i_cmd.nwords == '0) begin
                                o_res_push   = 1'b1;
                                o_res.status = bba_pkg::ST_FULL;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_ptr   = '0;
                                n_nw    = NWW'(i_cmd.nwords);
                                n_state = S_SCAN;
                            end
                        end
                        bba_pkg::CMD_REL: begin
                            rd_en   = 1'b1;
                            rd_addr = cmd_idx[IDXW-1:bba_pkg::BIT_W];
                            n_idx   = cmd_idx;
                            n_state = S_REL;
                        end
                        default: begin
                            o_res_push   = 1'b1;
                            o_res.status = bba_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rdata != '0) begin
                    wr_en                 = 1'b1;
                    wr_data               = r_rdata & ~iso;
                    o_res_push            = 1'b1;
                    o_res.status          = bba_pkg::ST_GRANTED;
                    o_res.block_index     = grant_wide[bba_pkg::IDX_OUT_W-1:0];
                    o_res.granted_address = i_base_address
                        + (bba_pkg::ADDR_W'(grant_idx) << BLOCK_SHIFT);
                    n_state               = S_IDLE;
                end else if (last_word) begin
                    o_res_push   = 1'b1;
                    o_res.status = bba_pkg::ST_FULL;
                    n_state      = S_IDLE;
                end else begin
                    // next word read overlaps the zero check
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end
            end
            S_REL: begin
                wr_en             = 1'b1;
                wr_addr           = r_idx[IDXW-1:bba_pkg::BIT_W];
                wr_data           = r_rdata
                    | (bba_pkg::WORD_W'(1) << r_idx[bba_pkg::BIT_W-1:0]);
                o_res_push        = 1'b1;
                o_res.status      = bba_pkg::ST_RELEASED;
                o_res.block_index = rel_wide[bba_pkg::IDX_OUT_W-1:0];
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_clearing = (r_state == S_CLR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_nw  <= n_nw;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

// File: rtl/bitmap_block_allocator.sv
// ---------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit allocator of fixed-size blocks over a free map of 32-bit words
// ---------------------------------------------------------------------------
//  channel   | ports                                    | transaction when
//  request   | push full opcode block_address           | push && !full
//  result    | pop empty status block_index granted_addr| pop && !empty
//  config    | psel penable pwrite paddr pwdata prdata  | psel && penable && pwrite
//
// release: through the command queue, a map read, then a map write that pushes the result
// allocate: words read from word 0 past the all-taken words to the first free bit,
//   one word read per cycle; a full region reads every word in use and reports full
// out-of-range release and allocate on an empty region: result pushed from idle, no map access
// after reset a clearing pass sets every map word to all free, full high
// a stalled result queue holds the engine; requests keep queuing until full
// ---------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int MAX_MAP_WORDS = 64,
    parameter int BLOCK_SHIFT   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_opcode,
    input  logic [bba_pkg::ADDR_W-1:0]    i_block_address,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_status,
    output logic [bba_pkg::IDX_OUT_W-1:0] o_block_index,
    output logic [bba_pkg::ADDR_W-1:0]    o_granted_address,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

`include "bitmap_block_allocator_macros.svh"

    logic [bba_pkg::WIU_W-1:0]  r_words_in_use;
    logic [bba_pkg::ADDR_W-1:0] r_base_address;

    logic          cfg_wr;
    logic          in_accept;
    logic          cmd_valid;
    bba_pkg::t_cmd cmd_in;
    bba_pkg::t_cmd cmd_out;
    logic          cmd_full;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          res_push;
    logic          res_full;
    bba_pkg::t_res res_in;
    bba_pkg::t_res res_out;
    logic          clearing;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_in_use <= bba_pkg::WORDS_RESET;
            r_base_address <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                bba_pkg::REG_WORDS: r_words_in_use <= pwdata[bba_pkg::WIU_W-1:0];
                bba_pkg::REG_BASE:  r_base_address <= pwdata[bba_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            bba_pkg::REG_WORDS: prdata = bba_pkg::PDATA_W'(r_words_in_use);
            bba_pkg::REG_BASE:  prdata = bba_pkg::PDATA_W'(r_base_address);
            default:            prdata = '0;
        endcase
    end

    // request side
    assign full      = cmd_full || clearing;
    assign in_accept = push && !full;

    bba_front #(
        .MAX_MAP_WORDS (MAX_MAP_WORDS),
        .BLOCK_SHIFT   (BLOCK_SHIFT)
    ) u_front (
        .i_valid         (in_accept),
        .i_opcode        (i_opcode),
        .i_block_address (i_block_address),
        .i_words_in_use  (r_words_in_use),
        .i_base_address  (r_base_address),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd_in)
    );

    bba_fifo #(
        .WIDTH ($bits(bba_pkg::t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    bba_back #(
        .MAX_MAP_WORDS (MAX_MAP_WORDS),
        .BLOCK_SHIFT   (BLOCK_SHIFT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!cmd_empty),
        .i_cmd          (cmd_out),
        .o_cmd_pop      (cmd_pop),
        .i_base_address (r_base_address),
        .i_res_full     (res_full),
        .o_res_push     (res_push),
        .o_res          (res_in),
        .o_clearing     (clearing)
    );

    // result side
    bba_fifo #(
        .WIDTH ($bits(bba_pkg::t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_status          = res_out.status;
    assign o_block_index     = res_out.block_index;
    assign o_granted_address = res_out.granted_address;

    `BBA_ASSERT(a_res_no_overflow, i_clk, i_rst_n,
        res_push |-> !res_full, "result pushed into full queue")
    `BBA_NEVER(a_cmd_pop_empty, i_clk, i_rst_n,
        cmd_pop && cmd_empty, "command popped from empty queue")
    `BBA_ASSERT(a_fail_fields_zero, i_clk, i_rst_n,
        res_push && (res_in.status == bba_pkg::ST_FULL || res_in.status == bba_pkg::ST_RANGE)
        |-> res_in.block_index == '0 && res_in.granted_address == '0,
        "failed request with nonzero fields")
    `BBA_ASSERT(a_clear_no_cmds, i_clk, i_rst_n,
        $fell(clearing) |-> cmd_empty, "command queued during map clearing")

endmodule
